/* sv/stable_priority_queue_macros.svh */
// Assertion macros shared by the stable priority queue RTL.
// Depends on nothing; expects clk and rst_n in the scope of each use.
`ifndef STABLE_PRIORITY_QUEUE_MACROS_SVH
`define STABLE_PRIORITY_QUEUE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SPQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/spq_pkg.sv */
// Types and constants of the stable priority queue.
// Used by spq_ram and stable_priority_queue; depends on nothing.
`default_nettype none

package spq_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int PRIO_W    = 16;
  localparam int TAG_W     = 16;
  localparam int OCC_W     = 5;
  localparam int ENTRY_W   = PRIO_W + TAG_W;

  typedef struct packed {
    logic signed [PRIO_W-1:0] prio;
    logic        [TAG_W-1:0]  tag;
  } entry_t;

  typedef enum logic [1:0] {
    STAT_INSERTED = 2'd0,
    STAT_SERVED   = 2'd1,
    STAT_EMPTY    = 2'd2,
    STAT_FULL     = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    FSM_IDLE,
    FSM_SERVE,
    FSM_INS_STEP,
    FSM_INS_PUT,
    FSM_RESULT
  } fsm_t;

endpackage

`default_nettype wire

/* sv/spq_ram.sv */
// Entry store of the stable priority queue: one write port, one registered read port.
// Depends on spq_pkg for the entry type.
`default_nettype none

module spq_ram #(
  parameter int DEPTH = spq_pkg::DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output spq_pkg::entry_t       rd_data,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire spq_pkg::entry_t  wr_data
);

  spq_pkg::entry_t mem [DEPTH];
  spq_pkg::entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

/* sv/stable_priority_queue.sv */
// Top level of the stable priority queue: control sequencer around a circular entry store.
// Depends on spq_pkg, spq_ram and stable_priority_queue_macros.svh.
//
//   channel  direction  handshake          payload
//   in       input      in_valid/in_stall  in_kind, in_priority_req, in_item_tag
//   out      output     out_valid/out_stall out_status, out_priority, out_tag,
//                                          out_occupancy
//
// A serve passes through the serve and result states; an empty serve, a full insert and
// an insert into an empty queue go from idle straight to the result state. An insert moves
// each lower-priority entry up one place in a read-compare-write loop on the store.
// Reset clears state, count, head pointer and out_valid only; no clearing pass is run.
// A new request is taken while an earlier result waits under out_stall.
`default_nettype none
`include "stable_priority_queue_macros.svh"

module stable_priority_queue #(
  parameter int QUEUE_DEPTH = spq_pkg::DEPTH_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic                              in_kind,
  input  wire logic signed [spq_pkg::PRIO_W-1:0] in_priority_req,
  input  wire logic        [spq_pkg::TAG_W-1:0]  in_item_tag,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic             [1:0]                 out_status,
  output logic signed [spq_pkg::PRIO_W-1:0]      out_priority,
  output logic        [spq_pkg::TAG_W-1:0]       out_tag,
  output logic        [spq_pkg::OCC_W-1:0]       out_occupancy
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  spq_pkg::fsm_t    state_r, state_nxt;
  logic [AW-1:0]    head_r, head_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic [AW-1:0]    idx_r, idx_nxt;
  spq_pkg::entry_t  req_r, req_nxt;
  spq_pkg::status_t res_status_r, res_status_nxt;
  spq_pkg::entry_t  res_entry_r, res_entry_nxt;

  logic                        out_valid_r, out_valid_nxt;
  spq_pkg::status_t            out_status_r, out_status_nxt;
  spq_pkg::entry_t             out_entry_r, out_entry_nxt;
  logic [spq_pkg::OCC_W-1:0]   out_occ_r, out_occ_nxt;

  logic            rd_en;
  logic [AW-1:0]   rd_addr;
  spq_pkg::entry_t rd_data;
  logic            wr_en;
  logic [AW-1:0]   wr_addr;
  spq_pkg::entry_t wr_data;

  function automatic logic [AW-1:0] phys(input logic [AW-1:0] base, input logic [AW-1:0] off);
    logic [AW:0] s;
    s = {1'b0, base} + {1'b0, off};
    if (s >= (AW+1)'(QUEUE_DEPTH)) begin
      s = s - (AW+1)'(QUEUE_DEPTH);
    end
    return s[AW-1:0];
  endfunction

  spq_ram #(
    .DEPTH (QUEUE_DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= spq_pkg::FSM_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    req_r        <= req_nxt;
    res_status_r <= res_status_nxt;
    res_entry_r  <= res_entry_nxt;
    out_status_r <= out_status_nxt;
    out_entry_r  <= out_entry_nxt;
    out_occ_r    <= out_occ_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    head_nxt       = head_r;
    count_nxt      = count_r;
    idx_nxt        = idx_r;
    req_nxt        = req_r;
    res_status_nxt = res_status_r;
    res_entry_nxt  = res_entry_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_entry_nxt  = out_entry_r;
    out_occ_nxt    = out_occ_r;
    rd_en          = 1'b0;
    rd_addr        = head_r;
    wr_en          = 1'b0;
    wr_addr        = head_r;
    wr_data        = req_r;

    unique case (state_r)
      spq_pkg::FSM_IDLE: begin
        if (in_valid) begin
          req_nxt       = '{prio: in_priority_req, tag: in_item_tag};
          res_entry_nxt = '0;
          if (in_kind) begin
            if (count_r == '0) begin
              res_status_nxt = spq_pkg::STAT_EMPTY;
              state_nxt      = spq_pkg::FSM_RESULT;
            end else begin
              rd_en     = 1'b1;
              rd_addr   = head_r;
              state_nxt = spq_pkg::FSM_SERVE;
            end
          end else if (count_r == CW'(QUEUE_DEPTH)) begin
            res_status_nxt = spq_pkg::STAT_FULL;
            state_nxt      = spq_pkg::FSM_RESULT;
          end else if (count_r == '0) begin
            wr_en          = 1'b1;
            wr_addr        = head_r;
            wr_data        = '{prio: in_priority_req, tag: in_item_tag};
            count_nxt      = count_r + CW'(1);
            res_status_nxt = spq_pkg::STAT_INSERTED;
            state_nxt      = spq_pkg::FSM_RESULT;
          end else begin
            idx_nxt   = AW'(count_r - CW'(1));
            rd_en     = 1'b1;
            rd_addr   = phys(head_r, AW'(count_r - CW'(1)));
            state_nxt = spq_pkg::FSM_INS_STEP;
          end
        end
      end
      spq_pkg::FSM_SERVE: begin
        res_status_nxt = spq_pkg::STAT_SERVED;
        res_entry_nxt  = rd_data;
        head_nxt       = phys(head_r, AW'(1));
        count_nxt      = count_r - CW'(1);
        state_nxt      = spq_pkg::FSM_RESULT;
      end
      spq_pkg::FSM_INS_STEP: begin
        wr_en   = 1'b1;
        wr_addr = phys(head_r, idx_r + AW'(1));
        if ($signed(rd_data.prio) >= $signed(req_r.prio)) begin
          wr_data        = req_r;
          count_nxt      = count_r + CW'(1);
          res_status_nxt = spq_pkg::STAT_INSERTED;
          state_nxt      = spq_pkg::FSM_RESULT;
        end else begin
          wr_data = rd_data;
          if (idx_r == '0) begin
            state_nxt = spq_pkg::FSM_INS_PUT;
          end else begin
            idx_nxt = idx_r - AW'(1);
            rd_en   = 1'b1;
            rd_addr = phys(head_r, idx_r - AW'(1));
          end
        end
      end
      spq_pkg::FSM_INS_PUT: begin
        wr_en          = 1'b1;
        wr_addr        = head_r;
        wr_data        = req_r;
        count_nxt      = count_r + CW'(1);
        res_status_nxt = spq_pkg::STAT_INSERTED;
        state_nxt      = spq_pkg::FSM_RESULT;
      end
      spq_pkg::FSM_RESULT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_entry_nxt  = res_entry_r;
          out_occ_nxt    = spq_pkg::OCC_W'(count_r);
          state_nxt      = spq_pkg::FSM_IDLE;
        end
      end
      default: begin
        state_nxt = spq_pkg::FSM_IDLE;
      end
    endcase
  end

  assign in_stall      = (state_r != spq_pkg::FSM_IDLE);
  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_priority  = out_entry_r.prio;
  assign out_tag       = out_entry_r.tag;
  assign out_occupancy = out_occ_r;

  `SPQ_ASSERT_NOW(a_count_bound, 1'b1, count_r <= CW'(QUEUE_DEPTH), "Entry count beyond depth.")
  `SPQ_ASSERT_NOW(a_step_count, state_r == spq_pkg::FSM_INS_STEP,
                  (count_r != '0) && (count_r < CW'(QUEUE_DEPTH)), "Shift with bad count.")
  `SPQ_ASSERT_NOW(a_out_origin, out_valid_r && !$past(out_valid_r && out_stall),
                  $past(state_r) == spq_pkg::FSM_RESULT, "Result not from result state.")
  `SPQ_ASSERT_NOW(a_empty_occ, out_valid_r && (out_status_r == spq_pkg::STAT_EMPTY),
                  out_occ_r == '0, "Empty status with entries held.")
  `SPQ_ASSERT_NEXT(a_serve_count, state_r == spq_pkg::FSM_SERVE,
                   count_r == $past(count_r) - CW'(1), "Serve did not drop the count.")

endmodule

`default_nettype wire

/* dv/tb.sv */
// Self-checking testbench for stable_priority_queue: directed and random insert and serve requests.
// It predicts every result with its own sorted store and checks each one as it is accepted.
// Depends on spq_pkg and the stable_priority_queue RTL.
`default_nettype none

module tb;

  localparam int DEPTH = spq_pkg::DEPTH_DEF;
  localparam int PRIO_W = spq_pkg::PRIO_W;
  localparam int TAG_W = spq_pkg::TAG_W;
  localparam int OCC_W = spq_pkg::OCC_W;
  localparam int CYCLE_LIMIT = 600000;
  localparam int DRAIN_CYCLES = 40;
  localparam int RANDOM_REQUESTS = 700;
  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_SERVE = 1'b1;
  localparam logic signed [PRIO_W-1:0] PRIO_MAX = 16'sh7fff;
  localparam logic signed [PRIO_W-1:0] PRIO_MIN = 16'sh8000;

  typedef struct {
    logic kind;
    logic signed [PRIO_W-1:0] prio;
    logic [TAG_W-1:0] tag;
  } request_t;

  typedef struct {
    spq_pkg::status_t status;
    logic signed [PRIO_W-1:0] prio;
    logic [TAG_W-1:0] tag;
    logic [OCC_W-1:0] occupancy;
  } outcome_t;

  typedef enum logic [1:0] {
    GEN_FILL,
    GEN_DRAIN,
    GEN_MIX
  } gen_mode_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_kind = KIND_INSERT;
  logic signed [PRIO_W-1:0] in_priority_req = '0;
  logic [TAG_W-1:0] in_item_tag = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] out_status;
  logic signed [PRIO_W-1:0] out_priority;
  logic [TAG_W-1:0] out_tag;
  logic [OCC_W-1:0] out_occupancy;

  request_t pending_requests[$];
  outcome_t expected_outcomes[$];
  request_t next_req;
  outcome_t seen;

  logic signed [PRIO_W-1:0] shelf_prio[DEPTH];
  logic [TAG_W-1:0] shelf_tag[DEPTH];
  int shelf_count = 0;

  int mismatches = 0;
  int cycle_count = 0;
  int in_gap = 0;
  int in_calm = 0;
  int stall_left = 0;
  int out_calm = 0;
  int n_inserted = 0;
  int n_served = 0;
  int n_empty = 0;
  int n_full = 0;
  int peak_occupancy = 0;

  stable_priority_queue u_top (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_kind(in_kind),
    .in_priority_req(in_priority_req),
    .in_item_tag(in_item_tag),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_status(out_status),
    .out_priority(out_priority),
    .out_tag(out_tag),
    .out_occupancy(out_occupancy)
  );

  always #5 clk = ~clk;

  // Applies one request to the sorted store; ties go behind existing entries.
  function automatic outcome_t queue_apply(logic kind, logic signed [PRIO_W-1:0] prio,
                                           logic [TAG_W-1:0] tag);
    outcome_t res;
    int pos;
    res.status = spq_pkg::STAT_INSERTED;
    res.prio = '0;
    res.tag = '0;
    if (kind == KIND_SERVE) begin
      if (shelf_count == 0) begin
        res.status = spq_pkg::STAT_EMPTY;
      end else begin
        res.status = spq_pkg::STAT_SERVED;
        res.prio = shelf_prio[0];
        res.tag = shelf_tag[0];
        for (int i = 1; i < shelf_count; i++) begin
          shelf_prio[i-1] = shelf_prio[i];
          shelf_tag[i-1] = shelf_tag[i];
        end
        shelf_count--;
      end
    end else if (shelf_count >= DEPTH) begin
      res.status = spq_pkg::STAT_FULL;
    end else begin
      pos = 0;
      while (pos < shelf_count && shelf_prio[pos] >= prio) pos++;
      for (int i = shelf_count; i > pos; i--) begin
        shelf_prio[i] = shelf_prio[i-1];
        shelf_tag[i] = shelf_tag[i-1];
      end
      shelf_prio[pos] = prio;
      shelf_tag[pos] = tag;
      shelf_count++;
    end
    res.occupancy = shelf_count[OCC_W-1:0];
    return res;
  endfunction

  function automatic int idle_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 50);
  endfunction

  function automatic logic signed [PRIO_W-1:0] random_priority();
    case ($urandom_range(0, 9))
      0: return PRIO_MAX;
      1: return PRIO_MIN;
      2, 3, 4, 5: return PRIO_W'($urandom_range(0, 65535));
      default: return PRIO_W'(int'($urandom_range(0, 6)) - 3);
    endcase
  endfunction

  task automatic add_request(logic kind, logic signed [PRIO_W-1:0] prio, logic [TAG_W-1:0] tag);
    request_t req;
    req.kind = kind;
    req.prio = prio;
    req.tag = tag;
    pending_requests.push_back(req);
  endtask

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_outcomes.push_back(queue_apply(in_kind, in_priority_req, in_item_tag));
      end
      if (!in_valid || !in_stall) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (pending_requests.size() > 0) begin
          next_req = pending_requests.pop_front();
          in_kind <= next_req.kind;
          in_priority_req <= next_req.prio;
          in_item_tag <= next_req.tag;
          in_valid <= 1'b1;
          if (in_calm > 0) begin
            in_calm--;
          end else if ($urandom_range(0, 49) == 0) begin
            in_calm = $urandom_range(15, 60);
          end
          in_gap = (in_calm > 0) ? 0 : idle_length();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_outcomes.size() == 0) begin
          $error("unexpected result: status %0d, priority %0d, tag %0h", out_status,
                 out_priority, out_tag);
          mismatches++;
        end else begin
          seen = expected_outcomes.pop_front();
          if (out_status !== seen.status) begin
            $error("out_status: expected %0d, actual %0d", seen.status, out_status);
            mismatches++;
          end
          if (out_priority !== seen.prio) begin
            $error("out_priority: expected %0d, actual %0d", seen.prio, out_priority);
            mismatches++;
          end
          if (out_tag !== seen.tag) begin
            $error("out_tag: expected %0h, actual %0h", seen.tag, out_tag);
            mismatches++;
          end
          if (out_occupancy !== seen.occupancy) begin
            $error("out_occupancy: expected %0d, actual %0d", seen.occupancy, out_occupancy);
            mismatches++;
          end
          case (seen.status)
            spq_pkg::STAT_INSERTED: n_inserted++;
            spq_pkg::STAT_SERVED: n_served++;
            spq_pkg::STAT_EMPTY: n_empty++;
            spq_pkg::STAT_FULL: n_full++;
          endcase
          if (int'(seen.occupancy) > peak_occupancy) peak_occupancy = int'(seen.occupancy);
        end
      end
      if (stall_left == 0) begin
        if (out_calm > 0) begin
          out_calm--;
        end else if ($urandom_range(0, 199) == 0) begin
          out_calm = $urandom_range(40, 150);
        end
        stall_left = (out_calm > 0) ? 0 : idle_length();
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    gen_mode_t mode;
    int shadow;
    logic kind;
    int insert_pct;

    // Directed: empty serve, priority extremes, ties with the head and in the middle.
    add_request(KIND_SERVE, '0, '0);
    add_request(KIND_INSERT, PRIO_MIN, 16'hffff);
    add_request(KIND_INSERT, PRIO_MAX, 16'h0000);
    add_request(KIND_INSERT, 16'sd0, 16'h0001);
    add_request(KIND_INSERT, 16'sd0, 16'h0002);
    add_request(KIND_INSERT, PRIO_MAX, 16'h0003);
    add_request(KIND_INSERT, -16'sd1, 16'h0004);
    add_request(KIND_INSERT, 16'sd1, 16'h0005);
    repeat (8) add_request(KIND_SERVE, PRIO_MAX, 16'hffff);

    // Random: alternate fill and drain phases so that full and empty are reached often.
    mode = GEN_FILL;
    shadow = 0;
    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      insert_pct = (mode == GEN_FILL) ? 85 : (mode == GEN_DRAIN) ? 15 : 50;
      kind = ($urandom_range(0, 99) < insert_pct) ? KIND_INSERT : KIND_SERVE;
      add_request(kind, random_priority(), TAG_W'($urandom_range(0, 65535)));
      if (kind == KIND_INSERT && shadow < DEPTH) shadow++;
      if (kind == KIND_SERVE && shadow > 0) shadow--;
      case (mode)
        GEN_FILL: begin
          if (shadow == DEPTH && $urandom_range(0, 2) == 0) begin
            mode = ($urandom_range(0, 3) == 0) ? GEN_MIX : GEN_DRAIN;
          end
        end
        GEN_DRAIN: begin
          if (shadow == 0 && $urandom_range(0, 2) == 0) begin
            mode = ($urandom_range(0, 3) == 0) ? GEN_MIX : GEN_FILL;
          end
        end
        default: begin
          if ($urandom_range(0, 29) == 0) begin
            mode = ($urandom_range(0, 1) == 0) ? GEN_FILL : GEN_DRAIN;
          end
        end
      endcase
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_requests.size() != 0 || in_valid) @(posedge clk);
    while (expected_outcomes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Results: %0d inserted, %0d served, %0d empty serves, %0d full drops.",
             n_inserted, n_served, n_empty, n_full);
    $display("Peak occupancy %0d of %0d, %0d mismatches.", peak_occupancy, DEPTH, mismatches);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* stable_priority_queue.f */
+incdir+sv
sv/spq_pkg.sv
sv/spq_ram.sv
sv/stable_priority_queue.sv
dv/tb.sv
